[sv/gpm_pkg.sv]
// Shared types, constants and character classes for the German punctuation marker.
// No dependencies; used by gpm_dot_rules, german_punctuation_marker and gpm_checker.
package gpm_pkg;

	localparam int CP_W             = 21;
	localparam int RUN_W            = 4;
	localparam int MARK_W           = 7;
	localparam int WINDOW_DEPTH     = 4;
	localparam int PREV_CNT         = WINDOW_DEPTH - 1;
	localparam int OFFSET_WIDTH_DEF = 32;

	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	typedef logic [CP_W-1:0] cp_t;

	// Previous characters (index 0 is the newest) and the current word length.
	typedef struct packed {
		cp_t [PREV_CNT-1:0] prev;
		logic [RUN_W-1:0]   run;
	} window_t;

	// Outcome of one character: emit decision and the window after it.
	typedef struct packed {
		logic    emit;
		window_t next;
	} verdict_t;

	function automatic logic is_ch(input cp_t c, input logic [7:0] ch);
		return c == {{(CP_W-8){1'b0}}, ch};
	endfunction

	function automatic logic is_punct(input cp_t c);
		return is_ch(c, ":") || is_ch(c, ".") || is_ch(c, ";") || is_ch(c, ",") ||
			is_ch(c, "!") || is_ch(c, "?") || is_ch(c, "(") || is_ch(c, ")") ||
			is_ch(c, "-");
	endfunction

	function automatic logic is_digit(input cp_t c);
		return c >= CP_W'("0") && c <= CP_W'("9");
	endfunction

	function automatic logic is_ascii_letter(input cp_t c);
		return (c >= CP_W'("A") && c <= CP_W'("Z")) || (c >= CP_W'("a") && c <= CP_W'("z"));
	endfunction

	function automatic logic is_alpha(input cp_t c);
		return is_ascii_letter(c) ||
			is_ch(c, 8'hC4) || is_ch(c, 8'hE4) || is_ch(c, 8'hD6) ||
			is_ch(c, 8'hF6) || is_ch(c, 8'hDC) || is_ch(c, 8'hFC);
	endfunction

	function automatic logic is_cons(input cp_t c);
		cp_t l;
		l = c | CP_W'(32);
		return is_ascii_letter(c) &&
			!(is_ch(l, "a") || is_ch(l, "e") || is_ch(l, "i") ||
			  is_ch(l, "o") || is_ch(l, "u") || is_ch(l, "y"));
	endfunction

endpackage

[sv/gpm_dot_rules.sv]
// Classifies one character against the window: emit decision and next window.
// Depends on gpm_pkg (types and character class functions).
module gpm_dot_rules (
	input  gpm_pkg::cp_t     code_point,
	input  logic             first,
	input  gpm_pkg::window_t win,
	output gpm_pkg::verdict_t verdict
);

	gpm_pkg::window_t w;
	gpm_pkg::cp_t     c1, c2, c3;
	logic [gpm_pkg::RUN_W-1:0] wl;
	logic suppress;
	logic cons1, cons2, cons3;
	logic c0_punct;

	always_comb begin
		// a new text starts from an empty window
		w = first ? '0 : win;
		c1 = w.prev[0];
		c2 = w.prev[1];
		c3 = w.prev[2];
		wl = w.run;
		cons1 = gpm_pkg::is_cons(c1);
		cons2 = gpm_pkg::is_cons(c2);
		cons3 = gpm_pkg::is_cons(c3);
		c0_punct = gpm_pkg::is_punct(code_point);
	end

	always_comb begin
		suppress = 1'b0;
		if (gpm_pkg::is_digit(c1) || wl == gpm_pkg::RUN_W'(1)) begin
			suppress = 1'b1;
		end else if (gpm_pkg::is_alpha(c1)) begin
			if (c3 != '0) begin
				if (cons1 && cons2 && c2 != c1 &&
					(wl <= gpm_pkg::RUN_W'(3) || (cons3 && c3 != c2))) begin
					suppress = 1'b1;
				end
			end else if (cons1 && cons2) begin
				suppress = 1'b1;
			end
			if (gpm_pkg::is_ch(c1, "f") && gpm_pkg::is_ch(c2, "o") && gpm_pkg::is_ch(c3, "r"))
				suppress = 1'b1;
			if (gpm_pkg::is_ch(c1, "c") && wl <= gpm_pkg::RUN_W'(4))
				suppress = 1'b1;
			if ((gpm_pkg::is_ch(c1, "z") || gpm_pkg::is_ch(c1, "w") ||
				gpm_pkg::is_ch(c1, "v")) && cons2)
				suppress = 1'b1;
			if (gpm_pkg::is_ch(c1, "h") && !gpm_pkg::is_ch(c2, "c") && cons2)
				suppress = 1'b1;
			if (gpm_pkg::is_ch(c1, "k") && cons2 && !gpm_pkg::is_ch(c2, "c") &&
				!gpm_pkg::is_ch(c2, "l") && !gpm_pkg::is_ch(c2, "n") &&
				!gpm_pkg::is_ch(c2, "r"))
				suppress = 1'b1;
		end
	end

	always_comb begin
		verdict = '0;
		if (code_point != '0) begin
			if (gpm_pkg::is_ch(code_point, "."))
				verdict.emit = !suppress;
			else
				verdict.emit = c0_punct;
			// shift the window, newest at index 0
			for (int i = gpm_pkg::PREV_CNT - 1; i > 0; i--)
				verdict.next.prev[i] = w.prev[i-1];
			verdict.next.prev[0] = code_point;
			if (code_point > gpm_pkg::CP_W'(32) && !c0_punct)
				verdict.next.run = (wl == gpm_pkg::RUN_MAX) ? wl : wl + gpm_pkg::RUN_W'(1);
			else
				verdict.next.run = '0;
		end
	end

endmodule

[sv/german_punctuation_marker.sv]
// Top level of the German punctuation marker: input stage, window state, result register.
// Depends on gpm_pkg and gpm_dot_rules.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | code_point, byte_offset, first
//   out     | output    | out_valid/out_stall | mark_offset, mark_char
//
// One character per cycle sustained while the output is not stalled; a character passes
// the input register, then the result register, before its result is valid.
// The window update is combinational: the rule logic sits between the input
// register and the window/result registers.
// arst_n clears valid flags and the window; payload registers are not reset.
// A stalled result holds the output; the input stage keeps taking characters until it
// too is full, so in_stall rises only while the output is both valid and stalled.
module german_punctuation_marker #(
	parameter int OFFSET_WIDTH = gpm_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [gpm_pkg::CP_W-1:0]    code_point,
	input  logic [OFFSET_WIDTH-1:0]     byte_offset,
	input  logic                        first,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [OFFSET_WIDTH-1:0]     mark_offset,
	output logic [gpm_pkg::MARK_W-1:0]  mark_char
);

	logic                       valid_s1;
	gpm_pkg::cp_t               code_point_s1;
	logic [OFFSET_WIDTH-1:0]    offset_s1;
	logic                       first_s1;

	gpm_pkg::window_t           win_q;
	gpm_pkg::verdict_t          verdict;

	logic                       out_valid_q;
	logic [OFFSET_WIDTH-1:0]    mark_offset_q;
	logic [gpm_pkg::MARK_W-1:0] mark_char_q;

	logic out_free;
	logic advance;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	gpm_dot_rules u_rules (
		.code_point (code_point_s1),
		.first      (first_s1),
		.win        (win_q),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_point_s1 <= code_point;
			offset_s1     <= byte_offset;
			first_s1      <= first;
		end
	end

	// advance the window only when the transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= verdict.next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= verdict.emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && verdict.emit) begin
			mark_offset_q <= offset_s1;
			mark_char_q   <= code_point_s1[gpm_pkg::MARK_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign mark_offset = mark_offset_q;
	assign mark_char   = mark_char_q;

endmodule

[sv/gpm_checker.sv]
// Port-level checks for german_punctuation_marker, attached by bind.
// Depends on gpm_pkg for field widths.
module gpm_checker #(
	parameter int OFFSET_WIDTH = gpm_pkg::OFFSET_WIDTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [gpm_pkg::CP_W-1:0]   code_point,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [OFFSET_WIDTH-1:0]    mark_offset,
	input logic [gpm_pkg::MARK_W-1:0] mark_char
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mark_offset) && $stable(mark_char))
		else $error("result changed while stalled");

	// only punctuation leaves the block
	a_out_punct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mark_char == 7'h3A || mark_char == 7'h2E || mark_char == 7'h3B ||
			mark_char == 7'h2C || mark_char == 7'h21 || mark_char == 7'h3F ||
			mark_char == 7'h28 || mark_char == 7'h29 || mark_char == 7'h2D))
		else $error("non-punctuation result");

	// input backpressure only when the output side is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	// an end-of-text transaction followed directly by a free output produces nothing
	a_eot_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && code_point == '0 ##1 (!out_valid || !out_stall)
		|=> !out_valid)
		else $error("end of text produced a result");

endmodule

bind german_punctuation_marker gpm_checker #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_gpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.code_point  (code_point),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.mark_offset (mark_offset),
	.mark_char   (mark_char)
);
